>>> design/mufr_pkg.sv
package mufr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;

    localparam logic RESULT_PAYLOAD = 1'b0;
    localparam logic RESULT_END     = 1'b1;

    typedef enum logic [2:0] {
        PH_H1   = 3'd0,
        PH_H2   = 3'd1,
        PH_VER  = 3'd2,
        PH_CMD  = 3'd3,
        PH_LENH = 3'd4,
        PH_LENL = 3'd5,
        PH_DATA = 3'd6,
        PH_SUM  = 3'd7
    } t_phase;

endpackage

>>> design/mcu_uart_frame_receiver.sv
// Serial frame receiver. It takes one received byte per transfer and finds frames of the form
// 0x55, 0xAA, version, command, 16-bit big-endian length, payload, checksum. Each payload byte
// comes out as it arrives, with its index and the frame's header fields. The checksum byte gives
// one end result with the received and computed sums and the verdict. Header, version, command
// and length bytes give no result. A bad header byte is dropped and the search restarts with the
// next byte. The block takes one byte every cycle while the result side is not stalled. A byte
// is first held in the input register and then moves into the result register. The per-byte
// work is one phase decode and one 8-bit add of the running checksum. While the result
// register is full and stalled, the input register holds one more byte. Input stall rises
// only when both registers are full.
module mcu_uart_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_frame_command,
    output logic [7:0]  o_frame_version,
    output logic [15:0] o_frame_length,
    output logic        o_checksum_good,
    output logic [7:0]  o_received_sum,
    output logic [7:0]  o_computed_sum
);
    import mufr_pkg::*;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Frame state.
    t_phase      r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_ver, n_ver;
    logic [15:0] r_len, n_len;
    logic [15:0] r_byte_count, n_byte_count;
    logic [7:0]  r_sum, n_sum;

    // Result register.
    logic        r_out_valid;
    logic        r_kind;
    logic [7:0]  r_pbyte;
    logic [15:0] r_pidx;
    logic [7:0]  r_ocmd;
    logic [7:0]  r_over;
    logic [15:0] r_olen;
    logic        r_good;
    logic [7:0]  r_rsum;
    logic [7:0]  r_csum;

    logic        w_out_free;
    logic        w_advance;
    logic        w_in_accept;
    logic        w_has_result;
    logic [7:0]  w_sum_add;
    logic [15:0] w_count_inc;
    logic [15:0] w_len_full;

    assign w_out_free  = !r_out_valid || !i_res_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_rx_stall  = r_in_valid && !w_out_free;
    assign w_in_accept = i_rx_valid && !o_rx_stall;

    assign w_sum_add   = r_sum + r_in_byte;
    assign w_count_inc = r_byte_count + 16'd1;
    assign w_len_full  = {r_len[15:8], r_in_byte};

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_H1:   n_phase = (r_in_byte == HDR_FIRST) ? PH_H2 : PH_H1;
            PH_H2:   n_phase = (r_in_byte == HDR_SECOND) ? PH_VER : PH_H1;
            PH_VER:  n_phase = PH_CMD;
            PH_CMD:  n_phase = PH_LENH;
            PH_LENH: n_phase = PH_LENL;
            PH_LENL: n_phase = (w_len_full == 16'd0) ? PH_SUM : PH_DATA;
            PH_DATA: n_phase = (w_count_inc >= r_len) ? PH_SUM : PH_DATA;
            PH_SUM:  n_phase = PH_H1;
            default: n_phase = PH_H1;
        endcase
    end

    // Frame registers and result fields.
    always_comb begin
        n_cmd        = r_cmd;
        n_ver        = r_ver;
        n_len        = r_len;
        n_byte_count = r_byte_count;
        n_sum        = r_sum;
        w_has_result = 1'b0;
        unique case (r_phase)
            PH_H1: begin
                if (r_in_byte == HDR_FIRST) begin
                    n_sum = HDR_FIRST;
                end
            end
            PH_H2: begin
                if (r_in_byte == HDR_SECOND) begin
                    n_sum = w_sum_add;
                end
            end
            PH_VER: begin
                n_ver = r_in_byte;
                n_sum = w_sum_add;
            end
            PH_CMD: begin
                n_cmd = r_in_byte;
                n_sum = w_sum_add;
            end
            PH_LENH: begin
                n_len = {r_in_byte, 8'd0};
                n_sum = w_sum_add;
            end
            PH_LENL: begin
                n_len        = w_len_full;
                n_sum        = w_sum_add;
                n_byte_count = 16'd0;
            end
            PH_DATA: begin
                n_sum        = w_sum_add;
                n_byte_count = w_count_inc;
                w_has_result = 1'b1;
            end
            PH_SUM: begin
                w_has_result = 1'b1;
            end
            default: begin
                w_has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_H1;
            r_cmd        <= 8'd0;
            r_ver        <= 8'd0;
            r_len        <= 16'd0;
            r_byte_count <= 16'd0;
            r_sum        <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_phase      <= n_phase;
                r_cmd        <= n_cmd;
                r_ver        <= n_ver;
                r_len        <= n_len;
                r_byte_count <= n_byte_count;
                r_sum        <= n_sum;
            end
            if (w_out_free) begin
                r_out_valid <= w_advance && w_has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_advance && w_has_result) begin
            r_ocmd <= r_cmd;
            r_over <= r_ver;
            r_olen <= r_len;
            if (r_phase == PH_SUM) begin
                r_kind  <= RESULT_END;
                r_pbyte <= 8'd0;
                r_pidx  <= 16'd0;
                r_good  <= (r_in_byte == r_sum);
                r_rsum  <= r_in_byte;
                r_csum  <= r_sum;
            end else begin
                r_kind  <= RESULT_PAYLOAD;
                r_pbyte <= r_in_byte;
                r_pidx  <= r_byte_count;
                r_good  <= 1'b0;
                r_rsum  <= 8'd0;
                r_csum  <= w_sum_add;
            end
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_payload_byte  = r_pbyte;
    assign o_payload_index = r_pidx;
    assign o_frame_command = r_ocmd;
    assign o_frame_version = r_over;
    assign o_frame_length  = r_olen;
    assign o_checksum_good = r_good;
    assign o_received_sum  = r_rsum;
    assign o_computed_sum  = r_csum;

    // The input side only stalls when a byte already waits in the input register.
    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> r_in_valid)
        else $error("input stall raised with an empty input register");

    // A checksum byte always ends the frame.
    a_sum_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_phase == PH_SUM) |=> (r_phase == PH_H1))
        else $error("receiver did not return to header search after checksum");

    // The payload counter never reaches the declared length inside the payload.
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_byte_count < r_len))
        else $error("payload counter ran past the declared length");

    // An end result carries a verdict consistent with its two sums.
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result_kind == RESULT_END)
            |-> (o_checksum_good == (o_received_sum == o_computed_sum)))
        else $error("checksum verdict does not match the reported sums");

    // A header byte never produces a result in the next cycle.
    a_header_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_phase == PH_H1 || r_phase == PH_H2 || r_phase == PH_VER
            || r_phase == PH_CMD || r_phase == PH_LENH || r_phase == PH_LENL))
            |=> !o_res_valid)
        else $error("header byte produced a result");

endmodule
